// ===== sv/edss_pkg.sv =====
// Shared constants, types and state codes for the echo distance smoother.
`default_nettype none
package edss_pkg;

  localparam int WINDOW     = 5;
  localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int WIDTH_W    = 15;
  localparam int DIST_W     = 6;
  localparam int SUM_W      = DIST_W + CNT_W;
  localparam int DIV_CNT_W  = $clog2(SUM_W);
  localparam int QUO_W      = 10;
  localparam int ANGLE_W    = 8;
  localparam int CMP_W      = 13;

  localparam logic [WIDTH_W-1:0] WIDTH_CAP = 15'd30000;

  // width / 58 as (width * 4519) >> 18, low by at most one, fixed by one compare
  localparam logic [12:0]        RECIP_58  = 13'd4519;
  localparam int                 RECIP_SH  = 18;
  localparam logic [5:0]         US_PER_CM = 6'd58;

  localparam logic [DIST_W-1:0]  DIST_MIN  = 6'd5;
  localparam logic [DIST_W-1:0]  DIST_MAX  = 6'd50;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX   = 8'd180;
  localparam logic [ANGLE_W-1:0] ANGLE_SLOPE = 8'd3;

  // angle * 3000 / 180 == (angle * 50 * 43691) >> 17, exact for angle <= 180
  localparam logic [21:0]        ANGLE_TO_PULSE = 22'd2184550;
  localparam int                 PULSE_SH       = 17;
  localparam logic [11:0]        PULSE_BASE     = 12'd100;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [DIST_W-1:0] data;
  } edss_wr_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MUL   = 8'b0000_0010,
    ST_CORR  = 8'b0000_0100,
    ST_SUM   = 8'b0000_1000,
    ST_DRAIN = 8'b0001_0000,
    ST_DIV   = 8'b0010_0000,
    ST_MAP   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } edss_state_t;

endpackage
`default_nettype wire

// ===== sv/edss_store.sv =====
// Sample ring memory: one write port, one read port with registered data.
`default_nettype none
module edss_store
  import edss_pkg::*;
(
  input  wire logic              clk,
  input  wire edss_wr_t          wr,
  input  wire logic [SLOT_W-1:0] rd_addr,
  output logic      [DIST_W-1:0] rd_data
);

  logic [DIST_W-1:0] mem [WINDOW];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== sv/edss_div.sv =====
// Restoring divider, one quotient bit per cycle: sum / fill count.
`default_nettype none
module edss_div
  import edss_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic                  done,
  output logic      [SUM_W-1:0] quotient
);

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0]     quo_r, quo_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]     div_r, div_nxt;
  logic [CNT_W:0]       trial;
  logic                 fits;

  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? CNT_W'(trial - {1'b0, div_r}) : CNT_W'(trial);
      quo_nxt = {quo_r[SUM_W-2:0], fits};
      cnt_nxt = DIV_CNT_W'(cnt_r + 1'b1);
      if (cnt_r == DIV_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== sv/echo_distance_smoother_servo_top.sv =====
// Echo distance smoother: width to cm, 5-entry ring average, servo angle and compare value.
// Per beat: after the ring write, the read-back visits each filled slot in turn, then the
//   divider produces one quotient bit per cycle (9 bits) and raises its done flag.
// Input: one beat at a time; in_ready is high only while the sequencer idles,
//   and the next beat is taken while a finished result still waits in the output register.
// Reset (rst_n low, synchronous): sequencer idle, ring slot and fill count zero, no result.
//   Ring contents are not cleared; only slots below the fill count are ever read.
`default_nettype none
module echo_distance_smoother_servo_top
  import edss_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [WIDTH_W-1:0] in_echo_width_us,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [DIST_W-1:0]  out_avg_distance_cm,
  output logic      [ANGLE_W-1:0] out_servo_angle,
  output logic      [CMP_W-1:0]   out_servo_compare
);

  // ---------------------------------------------------------------- state
  edss_state_t       state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;       // next ring slot to write
  logic [CNT_W-1:0]  fill_r, fill_nxt;       // filled entries, 0..WINDOW
  logic [SLOT_W-1:0] rd_idx_r, rd_idx_nxt;   // read-back address
  logic              rd_v_r;                 // ring read data valid this cycle

  // per-beat datapath
  logic [WIDTH_W-1:0] w_r, w_nxt;
  logic [QUO_W-1:0]   q_r, q_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [DIST_W-1:0]  avg_r, avg_nxt;
  logic [ANGLE_W-1:0] angle_r, angle_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0]  out_avg_r, out_avg_nxt;
  logic [ANGLE_W-1:0] out_angle_r, out_angle_nxt;
  logic [CMP_W-1:0]   out_cmp_r, out_cmp_nxt;

  // ring memory and divider hookup
  edss_wr_t          mem_wr;
  logic [DIST_W-1:0] mem_rd_data;
  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  div_quo;
  logic [SUM_W-1:0]  div_dividend;

  // combinational helpers
  logic [27:0]        width_prod;
  logic [15:0]        q_times_58;
  logic [15:0]        div_rem;
  logic [QUO_W-1:0]   q_fixed;
  logic [DIST_W-1:0]  dist_cm;
  logic [29:0]        pulse_prod;
  logic [11:0]        pulse_half;
  logic               out_free;
  logic               in_beat;

  edss_store u_store (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (rd_idx_r),
    .rd_data (mem_rd_data)
  );

  edss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (fill_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // width / 58: reciprocal estimate is exact or one short
  assign width_prod = 28'(w_r) * 28'(RECIP_58);
  assign q_times_58 = 16'(q_r) * 16'(US_PER_CM);
  assign div_rem    = 16'(w_r) - q_times_58;
  assign q_fixed    = (div_rem >= 16'(US_PER_CM)) ? QUO_W'(q_r + 1'b1) : q_r;

  // clamp to 5..50 cm
  always_comb begin
    if (q_fixed > QUO_W'(DIST_MAX)) begin
      dist_cm = DIST_MAX;
    end else if (q_fixed < QUO_W'(DIST_MIN)) begin
      dist_cm = DIST_MIN;
    end else begin
      dist_cm = DIST_W'(q_fixed);
    end
  end

  // compare = 2 * (100 + angle * 3000 / 180)
  assign pulse_prod = 30'(angle_r) * 30'(ANGLE_TO_PULSE);
  assign pulse_half = 12'(pulse_prod >> PULSE_SH) + PULSE_BASE;

  assign div_dividend = sum_nxt;

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    fill_nxt      = fill_r;
    rd_idx_nxt    = rd_idx_r;
    w_nxt         = w_r;
    q_nxt         = q_r;
    sum_nxt       = rd_v_r ? SUM_W'(sum_r + SUM_W'(mem_rd_data)) : sum_r;
    avg_nxt       = avg_r;
    angle_nxt     = angle_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_avg_nxt   = out_avg_r;
    out_angle_nxt = out_angle_r;
    out_cmp_nxt   = out_cmp_r;
    mem_wr        = '{en: 1'b0, addr: slot_r, data: dist_cm};
    div_start     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          w_nxt     = (in_echo_width_us > WIDTH_CAP) ? WIDTH_CAP : in_echo_width_us;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        q_nxt     = QUO_W'(width_prod >> RECIP_SH);
        state_nxt = ST_CORR;
      end
      ST_CORR: begin
        // ring write; read-back starts next cycle so no forwarding is needed
        mem_wr.en  = 1'b1;
        slot_nxt   = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : SLOT_W'(slot_r + 1'b1);
        fill_nxt   = (fill_r < CNT_W'(WINDOW)) ? CNT_W'(fill_r + 1'b1) : fill_r;
        rd_idx_nxt = '0;
        sum_nxt    = '0;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        // ring fills from slot 0, so slots 0..fill-1 are the live ones
        rd_idx_nxt = SLOT_W'(rd_idx_r + 1'b1);
        if (CNT_W'(rd_idx_r) == CNT_W'(fill_r - 1'b1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          avg_nxt   = DIST_W'(div_quo);
          state_nxt = ST_MAP;
        end
      end
      ST_MAP: begin
        if (avg_r >= DIST_MAX) begin
          angle_nxt = '0;
        end else if (avg_r <= DIST_MIN) begin
          angle_nxt = ANGLE_MAX;
        end else begin
          angle_nxt = ANGLE_W'(ANGLE_W'(DIST_MAX - avg_r) * ANGLE_SLOPE);
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = avg_r;
          out_angle_nxt = angle_r;
          out_cmp_nxt   = CMP_W'({pulse_half, 1'b0});
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      fill_r      <= '0;
      rd_idx_r    <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      fill_r      <= fill_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rd_v_r      <= (state_r == ST_SUM);
      out_valid_r <= out_valid_nxt;
    end
    w_r         <= w_nxt;
    q_r         <= q_nxt;
    sum_r       <= sum_nxt;
    avg_r       <= avg_nxt;
    angle_r     <= angle_nxt;
    out_avg_r   <= out_avg_nxt;
    out_angle_r <= out_angle_nxt;
    out_cmp_r   <= out_cmp_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_avg_distance_cm = out_avg_r;
  assign out_servo_angle     = out_angle_r;
  assign out_servo_compare   = out_cmp_r;

  // ---------------------------------------------------------------- checks
  // one beat in flight: the sequencer leaves idle right after taking a beat
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while a beat is in flight");

  // read-back never runs on an empty ring (divisor would be zero)
  a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM || state_r == ST_DIV) |-> (fill_r != '0))
    else $error("ring read-back with zero fill count");

  // divider only finishes while the sequencer waits on it
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider done outside divide phase");

  // a blocked result holds the sequencer in its output phase
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) && out_valid && !out_ready |=> (state_r == ST_OUT) && out_valid)
    else $error("result dropped while output register was full");

endmodule
`default_nettype wire
